// ===== rtl/mvt_pkg.sv =====
// Package for the 4x4 matrix-vector transform core.
// Holds word widths, payload and command types, and the saturation helper.
// No dependencies.
package mvt_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // product after the fraction shift, and the exact sum of four of them
  localparam int TERM_BITS = 2 * WORD_BITS - FRAC_BITS;
  localparam int SUM_BITS  = TERM_BITS + 2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t UNIT     = word_t'(1) << FRAC_BITS;

  // item mode codes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_VECTOR = 2'd1;
  localparam logic [1:0] MODE_POINT  = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] row_sel;
    logic [1:0] col_sel;
    word_t      element_value;
    word_t      in_x;
    word_t      in_y;
    word_t      in_z;
    word_t      in_w;
  } in_item_t;

  typedef struct packed {
    word_t out_x;
    word_t out_y;
    word_t out_z;
    word_t out_w;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_VECTOR = 2'd1,
    OP_POINT  = 2'd2
  } op_t;

  // command passed from front to back through the queue
  typedef struct packed {
    op_t             op;
    logic [1:0]      row;
    logic [1:0]      col;
    word_t           elem;
    word_t [3:0]     vec;
  } cmd_t;

  function automatic word_t sat_word(input sum_t s);
    word_t r;
    if (s > sum_t'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (s < sum_t'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = word_t'(s);
    end
    return r;
  endfunction

endpackage

// ===== rtl/matrix_vector_transform_4x4_core.sv =====
// Top level of the 4x4 matrix-vector transform core.
// Instantiates mvt_front, mvt_queue and mvt_back; depends on mvt_pkg.
//
// The core holds a 4x4 matrix of signed Q16.16 words that comes out of reset
// as the identity. A load item (mode 0) writes one element at row_sel,
// col_sel and gives no result. A vector item (mode 1) returns the matrix
// times (x, y, z, w); a point item (mode 2) uses w = 1.0 and returns out_w
// as zero. Each product is taken exactly and shifted right by 16 (rounding
// toward minus infinity), the four terms of a row are summed exactly and the
// sum saturates to 32 bits. Mode 3 items are taken and dropped. The core
// takes one item per clock while the queue has room: the front decodes the
// item into a two-entry command queue, and the back pulls one command per
// cycle. A load updates the matrix as it leaves the queue, so it affects
// only later transforms. A transform runs through a stage of sixteen 32x32
// multipliers and a row-sum/saturate stage into the result register.
// Backpressure on the result side stalls the back, and the queue fills
// before item_ready drops.
module matrix_vector_transform_4x4_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  mvt_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output mvt_pkg::out_item_t result
);
  import mvt_pkg::*;

  // front to queue
  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;
  // queue to back
  logic qb_valid;
  logic qb_ready;
  cmd_t qb_cmd;

  mvt_front u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cmd_valid  (fq_valid),
    .cmd_ready  (fq_ready),
    .cmd        (fq_cmd)
  );

  mvt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_cmd    (qb_cmd)
  );

  mvt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (qb_valid),
    .cmd_ready    (qb_ready),
    .cmd          (qb_cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== rtl/mvt_front.sv =====
// Front end of the transform core: accepts items and turns them into commands.
// Depends on mvt_pkg.
module mvt_front (
  input  logic             item_valid,
  output logic             item_ready,
  input  mvt_pkg::in_item_t item,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output mvt_pkg::cmd_t    cmd
);
  import mvt_pkg::*;

  logic known;

  // unused mode is taken and dropped
  assign item_ready = cmd_ready;
  assign cmd_valid  = item_valid && known;

  always_comb begin
    known      = 1'b1;
    cmd.op     = OP_LOAD;
    cmd.row    = item.row_sel;
    cmd.col    = item.col_sel;
    cmd.elem   = item.element_value;
    cmd.vec[0] = item.in_x;
    cmd.vec[1] = item.in_y;
    cmd.vec[2] = item.in_z;
    cmd.vec[3] = item.in_w;
    unique case (item.mode)
      MODE_LOAD:   cmd.op = OP_LOAD;
      MODE_VECTOR: cmd.op = OP_VECTOR;
      MODE_POINT: begin
        cmd.op     = OP_POINT;
        cmd.vec[3] = UNIT;
      end
      default:     known = 1'b0;
    endcase
  end

endmodule

// ===== rtl/mvt_queue.sv =====
// Two-entry command queue between front and back of the transform core.
// Depends on mvt_pkg.
module mvt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  mvt_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mvt_pkg::cmd_t pop_cmd
);
  import mvt_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_BITS = $clog2(DEPTH);

  cmd_t                entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = count != (PTR_BITS+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/mvt_back.sv =====
// Back end of the transform core: matrix store, product stage, row sums
// with saturation and the result register. Depends on mvt_pkg.
module mvt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  mvt_pkg::cmd_t      cmd,
  output logic               result_valid,
  input  logic               result_ready,
  output mvt_pkg::out_item_t result
);
  import mvt_pkg::*;

  word_t                       mat   [4][4];
  logic signed [TERM_BITS-1:0] terms [4][4];
  logic signed [TERM_BITS-1:0] terms_next [4][4];
  logic                        p_valid;
  logic                        p_point;
  logic                        p_ready;
  logic                        out_take;
  logic                        is_load;
  word_t                       row_out [4];

  assign out_take  = !result_valid || result_ready;
  assign p_ready   = !p_valid || out_take;
  assign is_load   = cmd.op == OP_LOAD;
  // loads retire at once; transforms wait for the product stage
  assign cmd_ready = is_load || p_ready;

  // matrix store, identity after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          mat[r][c] <= (r == c) ? UNIT : '0;
        end
      end
    end else if (cmd_valid && is_load) begin
      mat[cmd.row][cmd.col] <= cmd.elem;
    end
  end

  // sixteen products, each shifted down by the fraction width
  always_comb begin
    logic signed [2*WORD_BITS-1:0] prod;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod = $signed(mat[r][c]) * $signed(cmd.vec[c]);
        terms_next[r][c] = TERM_BITS'(prod >>> FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= cmd_valid && !is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready) begin
      terms   <= terms_next;
      p_point <= cmd.op == OP_POINT;
    end
  end

  // exact row sums, then saturate
  always_comb begin
    sum_t s;
    for (int r = 0; r < 4; r++) begin
      s = sum_t'(terms[r][0]) + sum_t'(terms[r][1])
        + sum_t'(terms[r][2]) + sum_t'(terms[r][3]);
      row_out[r] = sat_word(s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_take) begin
      result_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      result.out_x <= row_out[0];
      result.out_y <= row_out[1];
      result.out_z <= row_out[2];
      result.out_w <= p_point ? '0 : row_out[3];
    end
  end

endmodule

// ===== dv/mvt_transform_checker.sv =====
// Checker for the 4x4 matrix-vector transform core.
// Follows the matrix through observed load transfers, predicts every transform
// result and compares it with the result channel. Depends on mvt_pkg.
module mvt_transform_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  mvt_pkg::in_item_t  item,
  input  logic               result_valid,
  input  logic               result_ready,
  input  mvt_pkg::out_item_t result,
  output int                 mismatch_count,
  output int                 results_due
);
  import mvt_pkg::*;

  word_t     matrix [16];
  out_item_t pending_results [$];
  out_item_t oldest;
  int        fails;

  function automatic word_t clamp_word(input longint s);
    if (s > longint'(WORD_MAX)) return WORD_MAX;
    if (s < longint'(WORD_MIN)) return WORD_MIN;
    return word_t'(s);
  endfunction

  // Each product is exact in 64 bits; shift floors, sum of four stays exact.
  function automatic out_item_t transform(input in_item_t it);
    word_t     vec [4];
    word_t     rows [4];
    longint    acc;
    out_item_t r;
    vec[0] = it.in_x;
    vec[1] = it.in_y;
    vec[2] = it.in_z;
    vec[3] = (it.mode == MODE_POINT) ? UNIT : it.in_w;
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int j = 0; j < 4; j++) begin
        acc += (longint'(matrix[i*4 + j]) * longint'(vec[j])) >>> FRAC_BITS;
      end
      rows[i] = clamp_word(acc);
    end
    r.out_x = rows[0];
    r.out_y = rows[1];
    r.out_z = rows[2];
    r.out_w = (it.mode == MODE_POINT) ? word_t'(0) : rows[3];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) matrix[i] = (i % 5 == 0) ? UNIT : word_t'(0);
      pending_results.delete();
      fails = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          if (fails < 10)
            $display("unexpected result transfer: x=%h y=%h z=%h w=%h",
                     result.out_x, result.out_y, result.out_z, result.out_w);
          fails++;
        end else begin
          oldest = pending_results.pop_front();
          if (result !== oldest) begin
            if (fails < 10)
              $display("result mismatch: expected x=%h y=%h z=%h w=%h, got x=%h y=%h z=%h w=%h",
                       oldest.out_x, oldest.out_y, oldest.out_z, oldest.out_w,
                       result.out_x, result.out_y, result.out_z, result.out_w);
            fails++;
          end
        end
      end
      if (item_valid && item_ready) begin
        case (item.mode)
          OP_LOAD:   matrix[{item.row_sel, item.col_sel}] = item.element_value;
          OP_VECTOR,
          OP_POINT:  pending_results.push_back(transform(item));
          default:   ;
        endcase
      end
    end
    mismatch_count <= fails;
    results_due    <= pending_results.size();
  end

endmodule

// ===== dv/matrix_vector_transform_4x4_core_test.sv =====
// Testbench top for the 4x4 matrix-vector transform core.
// Drives item and result channels, instantiates the core and mvt_transform_checker;
// depends on mvt_pkg.
module matrix_vector_transform_4x4_core_test;
  import mvt_pkg::*;

  // mode 3 has no name in the package; the core takes and drops it
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_item_t  item;
  logic      result_valid;
  logic      result_ready;
  out_item_t result;
  int        mismatch_count;
  int        results_due;
  // when set, neither side inserts gaps: back-to-back transfers
  bit        steady = 1'b0;

  always #5 clk = ~clk;

  matrix_vector_transform_4x4_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  mvt_transform_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // Gap length: mostly none, often short, now and then long.
  function automatic int gap_length();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Word mix: extremes, zero, small values that stay clear of saturation,
  // and full-range values.
  function automatic word_t rand_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return word_t'(0);
      3, 4, 5, 6:
        return word_t'($urandom_range(0, 32'h0008_0000)) - word_t'(32'h0004_0000);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic in_item_t load_item(input logic [1:0] r, input logic [1:0] c,
                                         input word_t v);
    in_item_t it;
    it = '0;
    it.mode          = MODE_LOAD;
    it.row_sel       = r;
    it.col_sel       = c;
    it.element_value = v;
    return it;
  endfunction

  function automatic in_item_t xform_item(input logic [1:0] m, input word_t x,
                                          input word_t y, input word_t z, input word_t w);
    in_item_t it;
    it = '0;
    it.mode = m;
    it.in_x = x;
    it.in_y = y;
    it.in_z = z;
    it.in_w = w;
    return it;
  endfunction

  // Random item: every field filled, whatever the mode, so unused fields
  // carry noise the core must ignore.
  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 30)      it.mode = MODE_LOAD;
    else if (r < 65) it.mode = MODE_VECTOR;
    else if (r < 92) it.mode = MODE_POINT;
    else             it.mode = MODE_UNUSED;
    it.row_sel       = 2'($urandom);
    it.col_sel       = 2'($urandom);
    it.element_value = rand_word();
    it.in_x          = rand_word();
    it.in_y          = rand_word();
    it.in_z          = rand_word();
    it.in_w          = rand_word();
    return it;
  endfunction

  // One item transfer. Valid stays high across back-to-back items so it is
  // never lowered and raised in the same step.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  // Sender holds off until every predicted result has been transferred out.
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // Result side: ready runs of random length broken by stalls.
  initial begin
    int on_len;
    int off_len;
    forever begin
      on_len = $urandom_range(1, 30);
      result_ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      off_len = gap_length();
      if (off_len > 0) begin
        result_ready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // identity matrix out of reset: extremes pass straight through
    send_item(xform_item(MODE_VECTOR, WORD_MAX, WORD_MIN, word_t'(0), word_t'(-1)));
    // point mode: w forced to one, w input ignored, out_w zero
    send_item(xform_item(MODE_POINT, WORD_MIN, WORD_MAX, word_t'(1), WORD_MAX));
    // unused mode: dropped, no result and no matrix change
    send_item(random_item() | in_item_t'({MODE_UNUSED, {($bits(in_item_t)-2){1'b0}}}));

    // row 0 all max, row 1 all min: drives both saturation directions
    for (int c = 0; c < 4; c++) send_item(load_item(2'd0, 2'(c), WORD_MAX));
    for (int c = 0; c < 4; c++) send_item(load_item(2'd1, 2'(c), WORD_MIN));
    send_item(xform_item(MODE_VECTOR, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    send_item(xform_item(MODE_VECTOR, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    send_item(xform_item(MODE_POINT, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN));

    // tiny negative element: product shift rounds toward minus infinity
    send_item(load_item(2'd2, 2'd2, word_t'(-1)));
    send_item(xform_item(MODE_VECTOR, word_t'(3), word_t'(-5), word_t'(1), word_t'(7)));
    send_item(load_item(2'd3, 2'd3, word_t'(32'h1234_5678)));
    send_item(xform_item(MODE_VECTOR, rand_word(), rand_word(), rand_word(), rand_word()));
    drain_results();

    // random phases; the third runs with no gaps on either side
    for (int phase = 0; phase < 4; phase++) begin
      steady = (phase == 2);
      repeat (100) send_item(random_item());
      drain_results();
    end
    steady = 1'b0;

    // let the pipeline settle so a stray late result would still be seen
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
